>>> rtl/rbcm_pkg.sv
// Package with the shared widths, constants and types of the rational Bezier curve map.
package rbcm_pkg;
    localparam int COORD_W    = 16;
    localparam int CF         = 15;
    localparam int T_W        = 32;
    localparam int WEIGHT_W   = 24;
    localparam int STEPS_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ACC_W      = 64;
    localparam int QUO_W      = 17;
    localparam logic [COORD_W-1:0]  COORD_ONE  = 16'h8000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 24'd13107200;
    localparam logic [STEPS_W-1:0]  STEPS_MIN  = 5'd6;
    localparam logic [STEPS_W-1:0]  STEPS_MAX  = 5'd30;
    localparam logic [T_W-1:0]      T_ONE      = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_W1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_W2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS = 3'd6;

    typedef struct packed {
        logic [COORD_W-1:0] c0;
        logic [COORD_W-1:0] c1;
        logic [COORD_W-1:0] c2;
        logic [COORD_W-1:0] c3;
    } coord_set_t;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        return (v > COORD_ONE) ? COORD_ONE : v;
    endfunction
endpackage

>>> rtl/rbcm_eval.sv
// Sequenced evaluator of one rational cubic coordinate over one shared multiplier and divider.
module rbcm_eval (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [rbcm_pkg::T_W-1:0]    t,
    input  logic [rbcm_pkg::WEIGHT_W-1:0] w1,
    input  logic [rbcm_pkg::WEIGHT_W-1:0] w2,
    input  rbcm_pkg::coord_set_t        coords,
    output logic                        done,
    output logic [rbcm_pkg::QUO_W-1:0]  result
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_U2   = 5'd1;
    localparam logic [4:0] S_T2   = 5'd2;
    localparam logic [4:0] S_UT   = 5'd3;
    localparam logic [4:0] S_B0   = 5'd4;
    localparam logic [4:0] S_B1   = 5'd5;
    localparam logic [4:0] S_B2   = 5'd6;
    localparam logic [4:0] S_B3   = 5'd7;
    localparam logic [4:0] S_B1W  = 5'd8;
    localparam logic [4:0] S_B2W  = 5'd9;
    localparam logic [4:0] S_N0   = 5'd10;
    localparam logic [4:0] S_N1   = 5'd11;
    localparam logic [4:0] S_N2   = 5'd12;
    localparam logic [4:0] S_N3   = 5'd13;
    localparam logic [4:0] S_DIV  = 5'd14;
    localparam logic [4:0] S_DONE = 5'd15;

    logic [4:0]  state_reg, state_next;
    logic [31:0] u_reg, t_reg, u2_reg, t2_reg, ut_reg;
    logic [33:0] b0_reg, b1_reg, b2_reg, b3_reg;
    logic [39:0] b1w_reg, b2w_reg;
    logic [rbcm_pkg::ACC_W-1:0] num_reg, den_reg, rem_reg;
    logic [rbcm_pkg::QUO_W-1:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic [39:0] ma;
    logic [31:0] mb;
    logic [71:0] prod;
    logic [rbcm_pkg::ACC_W:0] trial;
    logic [rbcm_pkg::ACC_W-1:0] num_sum;

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            S_U2:    begin ma = {8'd0, u_reg};  mb = u_reg; end
            S_T2:    begin ma = {8'd0, t_reg};  mb = t_reg; end
            S_UT:    begin ma = {8'd0, u_reg};  mb = t_reg; end
            S_B0:    begin ma = {8'd0, u2_reg}; mb = u_reg; end
            S_B1:    begin ma = {8'd0, u2_reg}; mb = t_reg; end
            S_B2:    begin ma = {8'd0, ut_reg}; mb = t_reg; end
            S_B3:    begin ma = {8'd0, t2_reg}; mb = t_reg; end
            S_B1W:   begin ma = {6'd0, b1_reg}; mb = {8'd0, w1}; end
            S_B2W:   begin ma = {6'd0, b2_reg}; mb = {8'd0, w2}; end
            S_N0:    begin ma = {6'd0, b0_reg}; mb = {16'd0, coords.c0}; end
            S_N1:    begin ma = b1w_reg;        mb = {16'd0, coords.c1}; end
            S_N2:    begin ma = b2w_reg;        mb = {16'd0, coords.c2}; end
            S_N3:    begin ma = {6'd0, b3_reg}; mb = {16'd0, coords.c3}; end
            default: begin ma = '0;             mb = '0; end
        endcase
        prod = ma * {8'd0, mb};
        num_sum = num_reg + prod[63:0];
        trial = {rem_reg, num_reg[rbcm_pkg::ACC_W-1]} - {1'b0, den_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = go ? S_U2 : S_IDLE;
            S_DIV:   state_next = (cnt_reg == 5'd0) ? S_DONE : S_DIV;
            S_DONE:  state_next = S_IDLE;
            default: state_next = state_reg + 5'd1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                t_reg <= t;
                u_reg <= rbcm_pkg::T_ONE - t;
                num_reg <= '0;
            end
            S_U2:  u2_reg <= prod[62:31];
            S_T2:  t2_reg <= prod[62:31];
            S_UT:  ut_reg <= prod[62:31];
            S_B0:  b0_reg <= {2'd0, prod[62:31]};
            S_B1:  b1_reg <= {2'd0, prod[62:31]} * 34'd3;
            S_B2:  b2_reg <= {2'd0, prod[62:31]} * 34'd3;
            S_B3:  b3_reg <= {2'd0, prod[62:31]};
            S_B1W: b1w_reg <= prod[55:16];
            S_B2W:
            begin
                b2w_reg <= prod[55:16];
                den_reg <= {30'd0, b0_reg} + {24'd0, b1w_reg}
                         + {24'd0, prod[55:16]} + {30'd0, b3_reg};
            end
            S_N0:  num_reg <= num_sum;
            S_N1:  num_reg <= num_sum;
            S_N2:  num_reg <= num_sum;
            S_N3:
            begin
                if (den_reg == '0)
                begin
                    den_reg <= 64'd1;
                end
                rem_reg <= num_sum >> 17;
                num_reg <= num_sum << 47;
                quo_reg <= '0;
                cnt_reg <= 5'd16;
            end
            S_DIV:
            begin
                // Quotient fits in 17 bits, so the first 47 numerator bits only shift into rem.
                if (!trial[rbcm_pkg::ACC_W])
                begin
                    rem_reg <= trial[rbcm_pkg::ACC_W-1:0];
                end
                else
                begin
                    rem_reg <= {rem_reg[rbcm_pkg::ACC_W-2:0], num_reg[rbcm_pkg::ACC_W-1]};
                end
                quo_reg <= {quo_reg[rbcm_pkg::QUO_W-2:0], ~trial[rbcm_pkg::ACC_W]};
                num_reg <= {num_reg[rbcm_pkg::ACC_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 5'd1;
            end
            default: ;
        endcase
    end

    assign done   = (state_reg == S_DONE);
    assign result = quo_reg;
endmodule

>>> rtl/rational_bezier_curve_map.sv
// Top level of the rational cubic Bezier curve map: registers, bisection sequencer, output.
//
// Use: write the seven configuration registers through cfg_we, cfg_index and
// cfg_data while the block is idle. Pulse start with pos_in while busy is low;
// the beat is taken on that edge and busy rises. When the mapping is done the
// result appears on pos_out for one cycle with done high; busy falls then.
// An input at or outside the end points goes from the check straight to the
// output. Otherwise each bisection step and the final evaluation run the shared
// multiplier and divider sequence; the bisection count is clamped to 6..30.
// The receiver cannot stall: the result is shown for one cycle only.
// Reset restores the register defaults and returns the sequencer to idle.
module rational_bezier_curve_map (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] pos_in,
    output logic        done,
    output logic [15:0] pos_out,
    input  logic        cfg_we,
    input  logic [rbcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbcm_pkg::CFG_DATA_W-1:0] cfg_data
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_FWAIT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [31:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [23:0] w1_reg, w2_reg;
    logic [4:0]  steps_reg, cnt_reg;
    logic [2:0]  state_reg;
    logic [15:0] x_reg, y_reg;
    logic [31:0] lo_reg, hi_reg;
    logic        done_reg;
    logic        ev_go, ev_done;
    logic [16:0] ev_res;
    logic [31:0] mid;
    logic [23:0] w1c, w2c;
    logic [4:0]  steps_c;
    rbcm_pkg::coord_set_t xs, ys, sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_reg <= '0;
            p1_reg <= '0;
            p2_reg <= 32'h8000_8000;
            p3_reg <= 32'h8000_8000;
            w1_reg <= 24'd65536;
            w2_reg <= 24'd65536;
            steps_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rbcm_pkg::REG_START: p0_reg <= cfg_data;
                rbcm_pkg::REG_C1:    p1_reg <= cfg_data;
                rbcm_pkg::REG_C2:    p2_reg <= cfg_data;
                rbcm_pkg::REG_END:   p3_reg <= cfg_data;
                rbcm_pkg::REG_W1:    w1_reg <= cfg_data[23:0];
                rbcm_pkg::REG_W2:    w2_reg <= cfg_data[23:0];
                rbcm_pkg::REG_STEPS: steps_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        xs.c0 = rbcm_pkg::clamp_coord(p0_reg[15:0]);
        xs.c1 = rbcm_pkg::clamp_coord(p1_reg[15:0]);
        xs.c2 = rbcm_pkg::clamp_coord(p2_reg[15:0]);
        xs.c3 = rbcm_pkg::clamp_coord(p3_reg[15:0]);
        ys.c0 = rbcm_pkg::clamp_coord(p0_reg[31:16]);
        ys.c1 = rbcm_pkg::clamp_coord(p1_reg[31:16]);
        ys.c2 = rbcm_pkg::clamp_coord(p2_reg[31:16]);
        ys.c3 = rbcm_pkg::clamp_coord(p3_reg[31:16]);
        w1c = (w1_reg > rbcm_pkg::WEIGHT_MAX) ? rbcm_pkg::WEIGHT_MAX : w1_reg;
        w2c = (w2_reg > rbcm_pkg::WEIGHT_MAX) ? rbcm_pkg::WEIGHT_MAX : w2_reg;
        steps_c = (steps_reg < rbcm_pkg::STEPS_MIN) ? rbcm_pkg::STEPS_MIN :
                  (steps_reg > rbcm_pkg::STEPS_MAX) ? rbcm_pkg::STEPS_MAX : steps_reg;
        mid = 32'((33'(lo_reg) + 33'(hi_reg)) >> 1);
        sel = (state_reg == S_FIN || state_reg == S_FWAIT) ? ys : xs;
        ev_go = (state_reg == S_SRCH) || (state_reg == S_FIN);
    end

    rbcm_eval u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (ev_go),
        .t      (mid),
        .w1     (w1c),
        .w2     (w2c),
        .coords (sel),
        .done   (ev_done),
        .result (ev_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_OUT);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    priority if (x_reg <= xs.c0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (x_reg >= xs.c3)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH:  state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (ev_done)
                    begin
                        state_reg <= (cnt_reg == 5'd1) ? S_FIN : S_SRCH;
                    end
                end
                S_FIN:   state_reg <= S_FWAIT;
                S_FWAIT:
                begin
                    if (ev_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                x_reg <= rbcm_pkg::clamp_coord(pos_in);
                lo_reg <= '0;
                hi_reg <= rbcm_pkg::T_ONE;
                cnt_reg <= steps_c;
            end
            S_CHECK:
            begin
                priority if (x_reg <= xs.c0)
                begin
                    y_reg <= ys.c0;
                end
                else if (x_reg >= xs.c3)
                begin
                    y_reg <= ys.c3;
                end
                else
                begin
                    y_reg <= '0;
                end
            end
            S_WAIT:
            begin
                if (ev_done)
                begin
                    if (ev_res < {1'b0, x_reg})
                    begin
                        lo_reg <= mid;
                    end
                    else
                    begin
                        hi_reg <= mid;
                    end
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
            S_FWAIT:
            begin
                if (ev_done)
                begin
                    y_reg <= (ev_res > {1'b0, rbcm_pkg::COORD_ONE}) ?
                             rbcm_pkg::COORD_ONE : ev_res[15:0];
                end
            end
            default: ;
        endcase
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign pos_out = y_reg;

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe held");
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> pos_out <= rbcm_pkg::COORD_ONE) else $error("result above one");
    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("busy during result");
endmodule
